// ===== sv/cc20_pkg.sv =====
// Shared types, constants and helpers for the ChaCha20 stream cipher unit.
// No dependencies; imported by every module of the block.
package cc20_pkg;

   localparam int NUM_WORDS  = 16;
   localparam int NUM_ROUNDS = 20;
   localparam int LANES      = 4;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;

   // register indexes on the configuration port
   localparam logic [2:0] REG_KEY0      = 3'd0;
   localparam logic [2:0] REG_KEY1      = 3'd1;
   localparam logic [2:0] REG_KEY2      = 3'd2;
   localparam logic [2:0] REG_KEY3      = 3'd3;
   localparam logic [2:0] REG_NONCE_LO  = 3'd4;
   localparam logic [2:0] REG_NONCE_HI  = 3'd5;
   localparam logic [2:0] REG_START_CTR = 3'd6;

   typedef logic [31:0] word_type;
   typedef word_type [NUM_WORDS-1:0] blk_type;

   typedef struct packed {
      logic abort;   // drop any block in flight and recompute
      logic take;    // finished block moves into the keystream chain
   } core_ctl_type;

   typedef struct packed {
      logic done;    // finished block available on ks_words
   } core_sts_type;

   function automatic word_type rotl16(input word_type v);
      return {v[15:0], v[31:16]};
   endfunction

   function automatic word_type rotl12(input word_type v);
      return {v[19:0], v[31:20]};
   endfunction

   function automatic word_type rotl8(input word_type v);
      return {v[23:0], v[31:24]};
   endfunction

   function automatic word_type rotl7(input word_type v);
      return {v[24:0], v[31:25]};
   endfunction

endpackage

// ===== sv/cc20_qround.sv =====
// ChaCha20 quarter round, one lane of the round engine.
// Depends on cc20_pkg.
module cc20_qround (
   input  cc20_pkg::word_type a_in,
   input  cc20_pkg::word_type b_in,
   input  cc20_pkg::word_type c_in,
   input  cc20_pkg::word_type d_in,
   output cc20_pkg::word_type a_out,
   output cc20_pkg::word_type b_out,
   output cc20_pkg::word_type c_out,
   output cc20_pkg::word_type d_out
);
   import cc20_pkg::*;

   word_type a1, b1, c1, d1, a2, c2;

   assign a1    = a_in + b_in;
   assign d1    = rotl16(d_in ^ a1);
   assign c1    = c_in + d1;
   assign b1    = rotl12(b_in ^ c1);
   assign a2    = a1 + b1;
   assign d_out = rotl8(d1 ^ a2);
   assign c2    = c1 + d_out;
   assign b_out = rotl7(b1 ^ c2);
   assign a_out = a2;
   assign c_out = c2;

endmodule

// ===== sv/cc20_ks_cell.sv =====
// One keystream cell: holds a word, loads in parallel or takes its neighbor's word.
// Depends on cc20_pkg.
module cc20_ks_cell (
   input  logic               clock,
   input  logic               load,
   input  logic               shift,
   input  cc20_pkg::word_type load_word,
   input  cc20_pkg::word_type next_word,
   output cc20_pkg::word_type word_q
);
   import cc20_pkg::*;

   word_type word_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end else if (shift) begin
         word_ff <= next_word;
      end
   end

   assign word_q = word_ff;

endmodule

// ===== sv/cc20_core.sv =====
// Round engine: one column or diagonal round per cycle over four quarter-round lanes.
// Depends on cc20_pkg and cc20_qround.
module cc20_core (
   input  logic                   clock,
   input  logic                   reset,
   input  cc20_pkg::blk_type      init_words,
   input  cc20_pkg::core_ctl_type ctl,
   output cc20_pkg::core_sts_type sts,
   output cc20_pkg::blk_type      ks_words
);
   import cc20_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [4:0] LAST_RND = 5'(NUM_ROUNDS - 1);

   logic [1:0] state_ff, state_in;
   logic [4:0] rnd_ff, rnd_in;
   blk_type    st_ff, st_in, rw;
   word_type   qa_in [LANES], qb_in [LANES], qc_in [LANES], qd_in [LANES];
   word_type   qa_out[LANES], qb_out[LANES], qc_out[LANES], qd_out[LANES];
   logic       diag;

   assign diag = rnd_ff[0];

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      assign qa_in[j] = st_ff[j];
      assign qb_in[j] = diag ? st_ff[4 + ((j + 1) & 3)]  : st_ff[4 + j];
      assign qc_in[j] = diag ? st_ff[8 + ((j + 2) & 3)]  : st_ff[8 + j];
      assign qd_in[j] = diag ? st_ff[12 + ((j + 3) & 3)] : st_ff[12 + j];

      cc20_qround u_qr (
         .a_in (qa_in[j]),  .b_in (qb_in[j]),  .c_in (qc_in[j]),  .d_in (qd_in[j]),
         .a_out(qa_out[j]), .b_out(qb_out[j]), .c_out(qc_out[j]), .d_out(qd_out[j])
      );
   end

   always_comb begin
      rw = st_ff;
      for (int j = 0; j < LANES; j++) begin
         rw[j] = qa_out[j];
         if (diag) begin
            rw[4 + ((j + 1) & 3)]  = qb_out[j];
            rw[8 + ((j + 2) & 3)]  = qc_out[j];
            rw[12 + ((j + 3) & 3)] = qd_out[j];
         end else begin
            rw[4 + j]  = qb_out[j];
            rw[8 + j]  = qc_out[j];
            rw[12 + j] = qd_out[j];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      st_in    = st_ff;
      case (state_ff)
         ST_IDLE: begin
            st_in    = init_words;
            rnd_in   = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            st_in  = rw;
            rnd_in = rnd_ff + 5'd1;
            if (rnd_ff == LAST_RND) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (ctl.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (ctl.abort) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   // feed-forward: add the initial state back
   for (genvar i = 0; i < NUM_WORDS; i++) begin : g_ff
      assign ks_words[i] = st_ff[i] + init_words[i];
   end

   assign sts.done = (state_ff == ST_DONE);

endmodule

// ===== sv/chacha20_stream_cipher_unit.sv =====
// ChaCha20 stream cipher unit: XORs 32-bit data beats with RFC 8439 keystream.
// Each accepted beat's result is registered and appears in the cycle after acceptance.
// One beat per cycle within a block while the result side is not stalled; a block
// takes 20 rounds in the round engine and is prefetched while the previous block
// drains. A restart beat is held until the engine has recomputed its block.
// Reset: synchronous, active high; configuration registers, counter and control state clear.
module chacha20_stream_cipher_unit (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_in,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last,
   input  logic        req_restart,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_data_out,
   output logic [2:0]  rsp_out_valid_bytes,
   output logic        rsp_out_last,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import cc20_pkg::*;

   // ---------------- configuration registers ----------------
   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, nonce_lo_ff;
   logic [31:0] nonce_hi_ff, start_ctr_ff;
   logic        cfg_wr;
   logic [2:0]  cfg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff      <= '0;
         key1_ff      <= '0;
         key2_ff      <= '0;
         key3_ff      <= '0;
         nonce_lo_ff  <= '0;
         nonce_hi_ff  <= '0;
         start_ctr_ff <= '0;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_KEY0:      key0_ff      <= pwdata;
            REG_KEY1:      key1_ff      <= pwdata;
            REG_KEY2:      key2_ff      <= pwdata;
            REG_KEY3:      key3_ff      <= pwdata;
            REG_NONCE_LO:  nonce_lo_ff  <= pwdata;
            REG_NONCE_HI:  nonce_hi_ff  <= pwdata[31:0];
            REG_START_CTR: start_ctr_ff <= pwdata[31:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_KEY0:      prdata = key0_ff;
         REG_KEY1:      prdata = key1_ff;
         REG_KEY2:      prdata = key2_ff;
         REG_KEY3:      prdata = key3_ff;
         REG_NONCE_LO:  prdata = nonce_lo_ff;
         REG_NONCE_HI:  prdata = {32'd0, nonce_hi_ff};
         REG_START_CTR: prdata = {32'd0, start_ctr_ff};
         default:       prdata = '0;
      endcase
   end

   // ---------------- block counter and initial state ----------------
   // ctr_ff is the counter of the block the engine is working on or holds.
   logic [31:0] ctr_ff, ctr_in;
   blk_type     init_words, eng_words;

   always_comb begin
      init_words[0]  = SIGMA0;
      init_words[1]  = SIGMA1;
      init_words[2]  = SIGMA2;
      init_words[3]  = SIGMA3;
      init_words[4]  = key0_ff[31:0];
      init_words[5]  = key0_ff[63:32];
      init_words[6]  = key1_ff[31:0];
      init_words[7]  = key1_ff[63:32];
      init_words[8]  = key2_ff[31:0];
      init_words[9]  = key2_ff[63:32];
      init_words[10] = key3_ff[31:0];
      init_words[11] = key3_ff[63:32];
      init_words[12] = ctr_ff;
      init_words[13] = nonce_lo_ff[31:0];
      init_words[14] = nonce_lo_ff[63:32];
      init_words[15] = nonce_hi_ff;
   end

   // ---------------- handshake control ----------------
   core_ctl_type core_ctl;
   core_sts_type core_sts;
   logic         chain_vld_ff, chain_vld_in;
   logic [3:0]   pos_ff, pos_in;
   logic         rst_seen_ff, rst_seen_in;
   logic         out_free, restart_act, accept, msg_end;
   logic [2:0]   nbytes;
   logic [31:0]  ks_word, byte_mask;
   word_type     cell_q [NUM_WORDS];
   logic         chain_load, chain_shift;

   assign out_free    = !rsp_valid || rsp_ready;
   // a restart beat first reloads the counter and drops the held block
   assign restart_act = req_valid && req_restart && !rst_seen_ff;
   assign req_ready   = out_free && !restart_act && (chain_vld_ff || core_sts.done);
   assign accept      = req_valid && req_ready;

   always_comb begin
      if (req_valid_bytes == 3'd0) begin
         nbytes = 3'd1;
      end else if (req_valid_bytes > 3'd4) begin
         nbytes = 3'd4;
      end else begin
         nbytes = req_valid_bytes;
      end
      case (nbytes)
         3'd1:    byte_mask = 32'h0000_00ff;
         3'd2:    byte_mask = 32'h0000_ffff;
         3'd3:    byte_mask = 32'h00ff_ffff;
         default: byte_mask = 32'hffff_ffff;
      endcase
   end

   // without a held block the first word comes straight from the engine
   assign ks_word = chain_vld_ff ? cell_q[0] : eng_words[0];
   assign msg_end = req_last || (nbytes != 3'd4) || (chain_vld_ff && pos_ff == 4'd15);

   assign chain_load  = accept && !chain_vld_ff;
   assign chain_shift = accept && chain_vld_ff;

   assign core_ctl.take  = chain_load;
   assign core_ctl.abort = cfg_wr || restart_act;

   always_comb begin
      ctr_in       = ctr_ff;
      chain_vld_in = chain_vld_ff;
      pos_in       = pos_ff;
      rst_seen_in  = rst_seen_ff;
      if (restart_act) begin
         ctr_in       = start_ctr_ff;
         chain_vld_in = 1'b0;
         pos_in       = '0;
         rst_seen_in  = 1'b1;
      end
      if (accept) begin
         rst_seen_in = 1'b0;
         if (chain_load) begin
            ctr_in = ctr_ff + 32'd1;
         end
         if (msg_end) begin
            chain_vld_in = 1'b0;
            pos_in       = '0;
         end else begin
            chain_vld_in = 1'b1;
            pos_in       = chain_vld_ff ? pos_ff + 4'd1 : 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff       <= '0;
         chain_vld_ff <= 1'b0;
         pos_ff       <= '0;
         rst_seen_ff  <= 1'b0;
      end else begin
         ctr_ff       <= ctr_in;
         chain_vld_ff <= chain_vld_in;
         pos_ff       <= pos_in;
         rst_seen_ff  <= rst_seen_in;
      end
   end

   // ---------------- round engine ----------------
   cc20_core u_core (
      .clock     (clock),
      .reset     (reset),
      .init_words(init_words),
      .ctl       (core_ctl),
      .sts       (core_sts),
      .ks_words  (eng_words)
   );

   // ---------------- keystream chain ----------------
   // While a block is held, cell 0 holds the word for the next beat; advance the row on each beat.
   // On load the row takes the block already shifted by one, word 0 being used now.
   for (genvar i = 0; i < NUM_WORDS; i++) begin : g_cell
      word_type ld_word, nx_word;
      if (i == NUM_WORDS - 1) begin : g_tail
         assign ld_word = '0;
         assign nx_word = '0;
      end else begin : g_body
         assign ld_word = eng_words[i + 1];
         assign nx_word = cell_q[i + 1];
      end
      cc20_ks_cell u_cell (
         .clock    (clock),
         .load     (chain_load),
         .shift    (chain_shift),
         .load_word(ld_word),
         .next_word(nx_word),
         .word_q   (cell_q[i])
      );
   end

   // ---------------- output register ----------------
   logic        rsp_vld_ff;
   logic [31:0] rsp_data_ff;
   logic [2:0]  rsp_nb_ff;
   logic        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (accept) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= (req_data_in ^ ks_word) & byte_mask;
         rsp_nb_ff   <= nbytes;
         rsp_last_ff <= req_last;
      end
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_data_out        = rsp_data_ff;
   assign rsp_out_valid_bytes = rsp_nb_ff;
   assign rsp_out_last        = rsp_last_ff;

endmodule

// ===== bench/chacha20_stream_cipher_unit_checker.sv =====
// Result checker for the ChaCha20 stream cipher unit: tracks register writes,
// predicts each output beat from its own keystream model and compares.
// Depends on cc20_pkg for the register indexes.
module chacha20_stream_cipher_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_data_in,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last,
   input  logic        req_restart,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_data_out,
   input  logic [2:0]  rsp_out_valid_bytes,
   input  logic        rsp_out_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending_beats
);
   timeunit 1ns;
   timeprecision 1ps;
   import cc20_pkg::*;

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        last;
   } cipher_beat_type;

   logic [63:0] key_q [4];
   logic [63:0] nonce_lo_q;
   logic [31:0] nonce_hi_q, start_ctr_q;

   logic [31:0] blk_ctr;
   logic [31:0] ks_words [16];
   logic [31:0] mixw [16];
   logic [3:0]  word_pos;
   logic        have_block;

   cipher_beat_type cipher_q [$];

   function automatic logic [31:0] rol(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   task automatic quarter(input int a, input int b, input int c, input int d);
      mixw[a] = mixw[a] + mixw[b]; mixw[d] = rol(mixw[d] ^ mixw[a], 16);
      mixw[c] = mixw[c] + mixw[d]; mixw[b] = rol(mixw[b] ^ mixw[c], 12);
      mixw[a] = mixw[a] + mixw[b]; mixw[d] = rol(mixw[d] ^ mixw[a], 8);
      mixw[c] = mixw[c] + mixw[d]; mixw[b] = rol(mixw[b] ^ mixw[c], 7);
   endtask

   task automatic refill_keystream();
      logic [31:0] seed [16];
      seed[0] = 32'h61707865; seed[1] = 32'h3320646e;
      seed[2] = 32'h79622d32; seed[3] = 32'h6b206574;
      for (int k = 0; k < 4; k++) begin
         seed[4 + 2*k] = key_q[k][31:0];
         seed[5 + 2*k] = key_q[k][63:32];
      end
      seed[12] = blk_ctr;
      seed[13] = nonce_lo_q[31:0];
      seed[14] = nonce_lo_q[63:32];
      seed[15] = nonce_hi_q;
      for (int i = 0; i < 16; i++) mixw[i] = seed[i];
      for (int r = 0; r < 10; r++) begin
         quarter(0, 4, 8, 12); quarter(1, 5, 9, 13);
         quarter(2, 6, 10, 14); quarter(3, 7, 11, 15);
         quarter(0, 5, 10, 15); quarter(1, 6, 11, 12);
         quarter(2, 7, 8, 13); quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks_words[i] = mixw[i] + seed[i];
      blk_ctr = blk_ctr + 32'd1;
      word_pos = 4'd0;
      have_block = 1'b1;
   endtask

   task automatic encrypt_beat(output cipher_beat_type res);
      logic [2:0]  nb;
      logic [31:0] mask;
      nb = req_valid_bytes;
      if (nb == 3'd0) nb = 3'd1;
      if (nb > 3'd4) nb = 3'd4;
      if (req_restart) begin
         blk_ctr = start_ctr_q;
         have_block = 1'b0;
         word_pos = 4'd0;
      end
      if (!have_block) refill_keystream();
      mask = (nb == 3'd4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nb)) - 32'd1);
      res.data = (req_data_in ^ ks_words[word_pos]) & mask;
      res.nbytes = nb;
      res.last = req_last;
      word_pos = word_pos + 4'd1;
      if (word_pos == 4'd0 || req_last || nb < 3'd4) begin
         have_block = 1'b0;
         word_pos = 4'd0;
      end
   endtask

   always @(posedge clock) begin
      cipher_beat_type want, got;
      if (reset) begin
         for (int k = 0; k < 4; k++) key_q[k] = '0;
         nonce_lo_q = '0; nonce_hi_q = '0; start_ctr_q = '0;
         blk_ctr = '0; word_pos = '0; have_block = 1'b0;
         cipher_q.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[5:3])
               REG_KEY0:      key_q[0] = pwdata;
               REG_KEY1:      key_q[1] = pwdata;
               REG_KEY2:      key_q[2] = pwdata;
               REG_KEY3:      key_q[3] = pwdata;
               REG_NONCE_LO:  nonce_lo_q = pwdata;
               REG_NONCE_HI:  nonce_hi_q = pwdata[31:0];
               REG_START_CTR: start_ctr_q = pwdata[31:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            encrypt_beat(want);
            cipher_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_data_out, rsp_out_valid_bytes, rsp_out_last};
            if (cipher_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result beat: data %h bytes %0d last %b",
                           got.data, got.nbytes, got.last);
            end else begin
               want = cipher_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp data %h bytes %0d last %b, got %h %0d %b",
                              want.data, want.nbytes, want.last,
                              got.data, got.nbytes, got.last);
               end
            end
         end
      end
      pending_beats = cipher_q.size();
   end

endmodule

// ===== bench/chacha20_stream_cipher_unit_test.sv =====
// Top of the ChaCha20 stream cipher unit regression: drives beats and register
// writes, applies random back-pressure and reports the verdict.
// Depends on cc20_pkg, chacha20_stream_cipher_unit and the checker module.
module chacha20_stream_cipher_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cc20_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 60;    // longer than one block computation

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [31:0] req_data_in;
   logic [2:0]  req_valid_bytes;
   logic        req_last, req_restart;
   logic        rsp_valid, rsp_ready;
   logic [31:0] rsp_data_out;
   logic [2:0]  rsp_out_valid_bytes;
   logic        rsp_out_last;
   logic        psel, penable, pwrite, pready;
   logic [5:0]  paddr;
   logic [63:0] pwdata, prdata;
   int          fail_count, pending_beats;
   int          sent_beats;
   int          cycle_count;

   chacha20_stream_cipher_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data_in(req_data_in),
      .req_valid_bytes(req_valid_bytes), .req_last(req_last),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data_out(rsp_data_out),
      .rsp_out_valid_bytes(rsp_out_valid_bytes), .rsp_out_last(rsp_out_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   chacha20_stream_cipher_unit_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run guard: any hang ends the run as a failure.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("chacha20_stream_cipher_unit regression: fail");
            $finish;
         end
      end
   end

   // Result side: random stall per beat, idle-free stretches, and one long
   // hold-off after a few hundred beats so the block backs up onto its input.
   initial begin
      int taken, gap;
      bit busy;
      taken = 0;
      busy = 1'b1;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (taken % 80 == 0) busy = ($urandom_range(0, 2) != 0);
         gap = busy ? $urandom_range(0, 10) : 0;
         if (taken == 300) gap = 600;
         if (gap > 0) begin
            @(posedge clock);
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end
         @(posedge clock);
         rsp_ready <= 1'b1;
         // advance until the beat is taken
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Draw a gap, drive one beat and hold it until accepted, then idle for the gap.
   bit send_busy;
   task automatic send_beat(input logic [31:0] d, input logic [2:0] nb,
                            input logic lst, input logic rst);
      int gap;
      if (sent_beats % 64 == 0) send_busy = ($urandom_range(0, 2) != 0);
      gap = send_busy ? $urandom_range(0, 10) : 0;
      req_valid       <= 1'b1;
      req_data_in     <= d;
      req_valid_bytes <= nb;
      req_last        <= lst;
      req_restart     <= rst;
      do @(posedge clock); while (!req_ready);
      sent_beats++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Write cycle: setup then access; pready is always high.
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Let every result drain and any keystream prefetch finish before writes.
   // Drop valid at once: the beat on the bus was already taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_beats != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_setting(input logic [63:0] k0, k1, k2, k3, nlo,
                               input logic [31:0] nhi, ctr);
      csr_write(REG_KEY0, k0);
      csr_write(REG_KEY1, k1);
      csr_write(REG_KEY2, k2);
      csr_write(REG_KEY3, k3);
      csr_write(REG_NONCE_LO, nlo);
      csr_write(REG_NONCE_HI, {32'd0, nhi});
      csr_write(REG_START_CTR, {32'd0, ctr});
   endtask

   // Random traffic: mostly well-formed messages of full words closed by a
   // last beat, with odd byte counts and stray flags mixed in as noise.
   task automatic random_messages(input int beats);
      int target, len;
      logic [2:0] nb;
      logic lst, rst;
      target = sent_beats + beats;
      while (sent_beats < target) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 48)
                                          : $urandom_range(1, 16);
         for (int i = 0; i < len; i++) begin
            nb  = 3'd4;
            lst = (i == len - 1);
            rst = (i == 0) && ($urandom_range(0, 2) == 0);
            if (lst) nb = 3'($urandom_range(1, 4));
            if ($urandom_range(0, 19) == 0) begin
               // noise: any 3-bit count, random flags
               nb  = 3'($urandom_range(0, 7));
               lst = 1'($urandom_range(0, 1));
               rst = 1'($urandom_range(0, 1));
            end
            send_beat($urandom, nb, lst, rst);
         end
      end
   endtask

   initial begin
      logic [31:0] ctr;
      sent_beats = 0;
      send_busy = 1'b1;
      reset = 1'b1;
      req_valid = 1'b0; req_data_in = '0; req_valid_bytes = 3'd4;
      req_last = 1'b0; req_restart = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: known key/nonce, a block crossing, odd byte counts.
      load_setting(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                   64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                   64'h4a00000009000000, 32'h00000000, 32'd1);
      for (int i = 0; i < 18; i++)
         send_beat(i[0] ? 32'hFFFF_FFFF : 32'h0, 3'd4, 1'b0, i == 0);
      send_beat(32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0);  // zero count acts as one
      send_beat(32'hA5A5_5A5A, 3'd5, 1'b0, 1'b0);  // saturates to four
      send_beat(32'h1234_5678, 3'd7, 1'b1, 1'b0);
      send_beat(32'hFFFF_FFFF, 3'd3, 1'b0, 1'b0);  // short word ends message
      send_beat(32'hFFFF_FFFF, 3'd2, 1'b1, 1'b1);
      send_beat(32'h0, 3'd6, 1'b1, 1'b1);
      wait_idle();
      csr_write(3'd7, {$urandom, $urandom});       // unmapped: ignored

      for (int p = 0; p < 8; p++) begin
         wait_idle();
         case (p)
            0: load_setting('0, '0, '0, '0, '0, '0, '0);
            1: load_setting('1, '1, '1, '1, '1, '1, '1);  // counter wraps
            2: load_setting('1, '0, '1, '0, '1, '0, 32'hFFFF_FFFE);
            default: begin
               ctr = $urandom;
               load_setting({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, $urandom, ctr);
            end
         endcase
         // first beat of each setting restarts so the new key takes effect
         send_beat($urandom, 3'd4, 1'b0, 1'b1);
         random_messages(210);
      end

      wait_idle();
      if (fail_count == 0)
         $display("chacha20_stream_cipher_unit regression: pass");
      else
         $display("chacha20_stream_cipher_unit regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
sv/cc20_pkg.sv
sv/cc20_qround.sv
sv/cc20_ks_cell.sv
sv/cc20_core.sv
sv/chacha20_stream_cipher_unit.sv
bench/chacha20_stream_cipher_unit_checker.sv
bench/chacha20_stream_cipher_unit_test.sv
